### sv/ybd_pkg.sv
// ----------------------------------------------------------------------------
// ybd_pkg
// Shared types, codes and the CRC-32 byte update for the yEnc body decoder.
// ----------------------------------------------------------------------------
package ybd_pkg;

  // Field widths
  localparam int COUNT_W = 29;
  localparam int CRC_W   = 32;

  // Saturation limit of the per-part byte counter
  localparam logic [COUNT_W-1:0] MAX_PART_BYTES = 29'd268435456;

  // CRC-32, reflected
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  // Input opcodes
  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_END_PART   = 2'd1;
  localparam logic [1:0] OP_START_FILE = 2'd2;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_ESC_EOL   = 3'd1;
  localparam logic [2:0] ERR_OVERLONG  = 3'd2;
  localparam logic [2:0] ERR_SIZE      = 3'd3;
  localparam logic [2:0] ERR_PART_CRC  = 3'd4;
  localparam logic [2:0] ERR_FILE_CRC  = 3'd5;

  // Special characters and offsets of the encoding
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] OFFSET     = 8'd42;
  localparam logic [7:0] ESC_OFFSET = 8'd64;
  localparam logic [7:0] ESC_CR_BYTE = CHAR_CR - ESC_OFFSET - OFFSET;

  // Command queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input word
  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       raw_byte;
    logic [CRC_W-1:0] declared_part_crc;
    logic             part_crc_present;
    logic [CRC_W-1:0] declared_file_crc;
    logic             file_crc_present;
    logic             last_part;
  } in_item_t;

  // Output word
  typedef struct packed {
    logic               kind;
    logic [7:0]         decoded_byte;
    logic [2:0]         error_code;
    logic [CRC_W-1:0]   part_crc;
    logic [CRC_W-1:0]   file_crc;
    logic [COUNT_W-1:0] part_byte_count;
    logic               last;
  } out_item_t;

  // Commands passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_BYTES,
    CMD_FLAG_ESC,
    CMD_END_PART,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic             two_bytes;
    logic             esc_err;
    logic [CRC_W-1:0] declared_part_crc;
    logic             part_crc_present;
    logic [CRC_W-1:0] declared_file_crc;
    logic             file_check;
  } cmd_t;

  // Fold one byte into a reflected CRC-32 register
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/ybd_front.sv
// ----------------------------------------------------------------------------
// ybd_front
// Accepts raw body words, tracks escape state and turns each word into at
// most one command for the back end.
// ----------------------------------------------------------------------------
module ybd_front import ybd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic esc_pend;
  logic esc_cr_pend;
  logic esc_pend_next;
  logic esc_cr_pend_next;
  logic cmd_valid;
  logic accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && cmd_valid;

  // Classify the word and build its command
  always_comb begin
    logic       have_cr;
    logic       have_second;
    logic       flag_esc;
    logic [7:0] second;
    have_cr          = 1'b0;
    have_second      = 1'b0;
    flag_esc         = 1'b0;
    second           = 8'd0;
    esc_pend_next    = esc_pend;
    esc_cr_pend_next = esc_cr_pend;
    cmd_valid        = 1'b0;
    push_cmd                   = '0;
    push_cmd.declared_part_crc = in_data.declared_part_crc;
    push_cmd.part_crc_present  = in_data.part_crc_present;
    push_cmd.declared_file_crc = in_data.declared_file_crc;
    push_cmd.file_check        = in_data.last_part && in_data.file_crc_present;
    case (in_data.opcode)
      OP_BYTE: begin
        if (esc_cr_pend && in_data.raw_byte == CHAR_LF) begin
          // escaped CR followed by LF: escape at line end
          esc_cr_pend_next = 1'b0;
          flag_esc         = 1'b1;
        end else begin
          if (esc_cr_pend) begin
            esc_cr_pend_next = 1'b0;
            have_cr          = 1'b1;
          end
          if (esc_pend) begin
            esc_pend_next = 1'b0;
            if (in_data.raw_byte == CHAR_LF) begin
              flag_esc = 1'b1;
            end else if (in_data.raw_byte == CHAR_CR) begin
              esc_cr_pend_next = 1'b1;
            end else begin
              have_second = 1'b1;
              second      = in_data.raw_byte - ESC_OFFSET - OFFSET;
            end
          end else if (in_data.raw_byte == CHAR_EQ) begin
            esc_pend_next = 1'b1;
          end else if (in_data.raw_byte != CHAR_CR && in_data.raw_byte != CHAR_LF) begin
            have_second = 1'b1;
            second      = in_data.raw_byte - OFFSET;
          end
        end
        if (flag_esc) begin
          cmd_valid     = 1'b1;
          push_cmd.kind = CMD_FLAG_ESC;
        end else if (have_cr || have_second) begin
          cmd_valid          = 1'b1;
          push_cmd.kind      = CMD_BYTES;
          push_cmd.byte0     = have_cr ? ESC_CR_BYTE : second;
          push_cmd.byte1     = second;
          push_cmd.two_bytes = have_cr && have_second;
        end
      end
      OP_END_PART: begin
        cmd_valid        = 1'b1;
        push_cmd.kind    = CMD_END_PART;
        push_cmd.esc_err = esc_pend || esc_cr_pend;
        esc_pend_next    = 1'b0;
        esc_cr_pend_next = 1'b0;
      end
      OP_START_FILE: begin
        cmd_valid        = 1'b1;
        push_cmd.kind    = CMD_START;
        esc_pend_next    = 1'b0;
        esc_cr_pend_next = 1'b0;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  // Hold escape state, advance it on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pend    <= 1'b0;
      esc_cr_pend <= 1'b0;
    end else if (accept) begin
      esc_pend    <= esc_pend_next;
      esc_cr_pend <= esc_cr_pend_next;
    end
  end

  a_esc_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(esc_pend && esc_cr_pend))
    else $error("escape and escaped CR pending together");

endmodule

### sv/ybd_fifo.sv
// ----------------------------------------------------------------------------
// ybd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ybd_fifo import ybd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_pop;

  assign full       = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + (FIFO_AW+1)'(1);
        2'b01:   fill <= fill - (FIFO_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into a full queue");

endmodule

### sv/ybd_back.sv
// ----------------------------------------------------------------------------
// ybd_back
// Executes commands: counts bytes, updates part and file CRCs, keeps the
// sticky error and drives the registered output word.
// ----------------------------------------------------------------------------
module ybd_back import ybd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               head_valid,
  input  cmd_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic [COUNT_W-1:0] exp_size;
  logic [COUNT_W-1:0] byte_count;
  logic [CRC_W-1:0]   part_crc;
  logic [CRC_W-1:0]   file_crc;
  logic [2:0]         sticky;
  logic               phase;

  logic               can_out;
  logic               step;
  logic [7:0]         cur_byte;
  logic [COUNT_W-1:0] count_next;
  logic [CRC_W-1:0]   part_crc_next;
  logic [CRC_W-1:0]   file_crc_next;
  logic [2:0]         byte_err_next;
  logic [2:0]         eop_err;
  logic [2:0]         eop_err_next;
  logic               byte_last;

  assign can_out  = !out_valid || out_ready;
  assign cur_byte = phase ? head.byte1 : head.byte0;
  assign byte_last = !head.two_bytes || phase;

  // Per-byte updates
  assign count_next    = (byte_count < MAX_PART_BYTES) ? byte_count + COUNT_W'(1) : byte_count;
  assign part_crc_next = crc32_byte(part_crc, cur_byte);
  assign file_crc_next = crc32_byte(file_crc, cur_byte);
  assign byte_err_next = (sticky == ERR_OK && byte_count >= exp_size) ? ERR_OVERLONG : sticky;

  // End-of-part checks, first failure wins
  always_comb begin
    if (head.esc_err) begin
      eop_err = ERR_ESC_EOL;
    end else if (byte_count != exp_size) begin
      eop_err = ERR_SIZE;
    end else if (head.part_crc_present && ((part_crc ^ CRC_INIT) != head.declared_part_crc)) begin
      eop_err = ERR_PART_CRC;
    end else if (head.file_check && ((file_crc ^ CRC_INIT) != head.declared_file_crc)) begin
      eop_err = ERR_FILE_CRC;
    end else begin
      eop_err = ERR_OK;
    end
  end
  assign eop_err_next = (sticky == ERR_OK) ? eop_err : sticky;

  // Decide whether the head command advances this cycle
  always_comb begin
    step = 1'b0;
    pop  = 1'b0;
    if (head_valid) begin
      case (head.kind)
        CMD_BYTES: begin
          step = can_out;
          pop  = can_out && byte_last;
        end
        CMD_END_PART: begin
          step = can_out;
          pop  = can_out;
        end
        CMD_FLAG_ESC, CMD_START: begin
          step = 1'b1;
          pop  = 1'b1;
        end
        default: begin
          step = 1'b0;
          pop  = 1'b0;
        end
      endcase
    end
  end

  // Hold the part size register
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_size <= COUNT_W'(1);
    end else if (cfg_valid) begin
      exp_size <= cfg_data;
    end
  end

  // Execute the head command and load the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      part_crc   <= CRC_INIT;
      file_crc   <= CRC_INIT;
      sticky     <= ERR_OK;
      phase      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        case (head.kind)
          CMD_BYTES: begin
            byte_count <= count_next;
            part_crc   <= part_crc_next;
            file_crc   <= file_crc_next;
            sticky     <= byte_err_next;
            phase      <= !byte_last;
            out_valid  <= 1'b1;
            out_data.kind            <= KIND_DATA;
            out_data.decoded_byte    <= cur_byte;
            out_data.error_code      <= byte_err_next;
            out_data.part_crc        <= part_crc_next ^ CRC_INIT;
            out_data.file_crc        <= file_crc_next ^ CRC_INIT;
            out_data.part_byte_count <= count_next;
            out_data.last            <= byte_last;
          end
          CMD_FLAG_ESC: begin
            if (sticky == ERR_OK) begin
              sticky <= ERR_ESC_EOL;
            end
          end
          CMD_END_PART: begin
            sticky     <= eop_err_next;
            byte_count <= '0;
            part_crc   <= CRC_INIT;
            out_valid  <= 1'b1;
            out_data.kind            <= KIND_SUMMARY;
            out_data.decoded_byte    <= 8'd0;
            out_data.error_code      <= eop_err_next;
            out_data.part_crc        <= part_crc ^ CRC_INIT;
            out_data.file_crc        <= file_crc ^ CRC_INIT;
            out_data.part_byte_count <= byte_count;
            out_data.last            <= 1'b1;
          end
          CMD_START: begin
            byte_count <= '0;
            part_crc   <= CRC_INIT;
            file_crc   <= CRC_INIT;
            sticky     <= ERR_OK;
          end
          default: begin
            phase <= 1'b0;
          end
        endcase
      end
    end
  end

  a_phase_two_bytes: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head.kind == CMD_BYTES && head.two_bytes))
    else $error("second byte phase without a two-byte command");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_PART_BYTES)
    else $error("byte count above saturation limit");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    (sticky != ERR_OK && !(step && head.kind == CMD_START)) |=> (sticky == $past(sticky)))
    else $error("sticky error changed without a start-file command");

endmodule

### sv/yenc_body_decoder_crc.sv
// ----------------------------------------------------------------------------
// yenc_body_decoder_crc
// yEnc body decoder with per-part size and CRC-32 checks and a running file
// CRC-32.
//
//   channel  dir  handshake            word
//   in       in   in_valid/in_ready    in_item_t (opcode, raw byte, trailer)
//   out      out  out_valid/out_ready  out_item_t (byte or part summary)
//   cfg      in   cfg_valid/cfg_ready  expected part size, 29 bits
//
// Accepts one input word per cycle while the four-entry command queue has
// room. A word yields at most one command; the back end emits one output
// word per cycle while out_ready allows, so an escaped CR followed by a data
// byte gives two output words. Reset is synchronous, with no clearing pass. The
// front end stalls only on a full queue; the back end stalls only on out_ready.
// ----------------------------------------------------------------------------
module yenc_body_decoder_crc import ybd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  ybd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ybd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ybd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw yEnc body words, end-of-part trailers and start-file words into
// the body decoder and checks every output word against a cycle-free
// prediction of the decoded bytes, byte counts, part and file CRC-32 values
// and the sticky error code. Runs with sender and receiver idling mixed,
// reversed and off, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import ybd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         HOLD_LEN    = 300;
  localparam int         SETTLE_CYC  = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  yenc_body_decoder_crc dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted decoder state
  logic [COUNT_W-1:0] part_size;
  logic               esc_open;
  logic               esc_cr_open;
  logic [COUNT_W-1:0] part_bytes;
  logic [CRC_W-1:0]   part_crc_reg;
  logic [CRC_W-1:0]   file_crc_reg;
  logic [2:0]         first_err;

  out_item_t due_words[$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int parts_closed = 0;
  int size_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Reflected CRC-32, one input bit at a time
  function automatic logic [CRC_W-1:0] crc32_fold(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ 32'hEDB88320;
    end
    return c;
  endfunction

  task automatic note_error(input logic [2:0] code);
    if (first_err == ERR_OK) first_err = code;
  endtask

  task automatic push_result(input logic kind, input logic [7:0] data);
    out_item_t r;
    r.kind            = kind;
    r.decoded_byte    = data;
    r.error_code      = first_err;
    r.part_crc        = ~part_crc_reg;
    r.file_crc        = ~file_crc_reg;
    r.part_byte_count = part_bytes;
    r.last            = 1'b0;
    due_words.push_back(r);
  endtask

  task automatic emit_decoded(input logic [7:0] data);
    if (part_bytes >= part_size) note_error(ERR_OVERLONG);
    if (part_bytes < MAX_PART_BYTES) part_bytes = part_bytes + 1'b1;
    part_crc_reg = crc32_fold(part_crc_reg, data);
    file_crc_reg = crc32_fold(file_crc_reg, data);
    push_result(KIND_DATA, data);
  endtask

  task automatic clear_file_state();
    esc_open     = 1'b0;
    esc_cr_open  = 1'b0;
    part_bytes   = '0;
    part_crc_reg = CRC_INIT;
    file_crc_reg = CRC_INIT;
    first_err    = ERR_OK;
  endtask

  // Work out the output words caused by one accepted input word
  task automatic forecast_decode(input in_item_t w);
    int        base;
    bit        done;
    out_item_t tail;
    base = due_words.size();
    done = 1'b0;
    case (w.opcode)
      OP_BYTE: begin
        if (esc_cr_open) begin
          esc_cr_open = 1'b0;
          if (w.raw_byte == CHAR_LF) begin
            note_error(ERR_ESC_EOL);
            done = 1'b1;
          end else begin
            emit_decoded(CHAR_CR - ESC_OFFSET - OFFSET);
          end
        end
        if (!done) begin
          if (esc_open) begin
            esc_open = 1'b0;
            if (w.raw_byte == CHAR_LF) note_error(ERR_ESC_EOL);
            else if (w.raw_byte == CHAR_CR) esc_cr_open = 1'b1;
            else emit_decoded(w.raw_byte - ESC_OFFSET - OFFSET);
          end else if (w.raw_byte == CHAR_EQ) begin
            esc_open = 1'b1;
          end else if (w.raw_byte != CHAR_CR && w.raw_byte != CHAR_LF) begin
            emit_decoded(w.raw_byte - OFFSET);
          end
        end
      end
      OP_END_PART: begin
        if (esc_open || esc_cr_open) note_error(ERR_ESC_EOL);
        if (part_bytes != part_size) note_error(ERR_SIZE);
        if (w.part_crc_present && ~part_crc_reg != w.declared_part_crc)
          note_error(ERR_PART_CRC);
        if (w.last_part && w.file_crc_present && ~file_crc_reg != w.declared_file_crc)
          note_error(ERR_FILE_CRC);
        push_result(KIND_SUMMARY, 8'h00);
        esc_open     = 1'b0;
        esc_cr_open  = 1'b0;
        part_bytes   = '0;
        part_crc_reg = CRC_INIT;
      end
      OP_START_FILE: clear_file_state();
      default: ;
    endcase
    // flag the final word of this input
    if (due_words.size() > base) begin
      tail = due_words.pop_back();
      tail.last = 1'b1;
      due_words.push_back(tail);
    end
  endtask

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------

  function automatic in_item_t byte_word(input logic [7:0] b);
    in_item_t w;
    w.opcode            = OP_BYTE;
    w.raw_byte          = b;
    w.declared_part_crc = $urandom;
    w.part_crc_present  = $urandom_range(1);
    w.declared_file_crc = $urandom;
    w.file_crc_present  = $urandom_range(1);
    w.last_part         = $urandom_range(1);
    return w;
  endfunction

  function automatic in_item_t end_word(input logic [CRC_W-1:0] pcrc, input logic pp,
                                        input logic [CRC_W-1:0] fcrc, input logic fp,
                                        input logic lastp);
    in_item_t w;
    w.opcode            = OP_END_PART;
    w.raw_byte          = $urandom;
    w.declared_part_crc = pcrc;
    w.part_crc_present  = pp;
    w.declared_file_crc = fcrc;
    w.file_crc_present  = fp;
    w.last_part         = lastp;
    return w;
  endfunction

  function automatic in_item_t op_word(input logic [1:0] op);
    in_item_t w;
    w = byte_word($urandom);
    w.opcode = op;
    return w;
  endfunction

  // Trailer built from the running CRCs, corrupted now and then
  function automatic in_item_t trailer_word(input logic final_part);
    logic [CRC_W-1:0] pcrc, fcrc;
    pcrc = ~part_crc_reg;
    fcrc = ~file_crc_reg;
    if ($urandom_range(9) == 0) pcrc[$urandom_range(31)] ^= 1'b1;
    if ($urandom_range(9) == 0) fcrc[$urandom_range(31)] ^= 1'b1;
    return end_word(pcrc, $urandom_range(6) != 0, fcrc, $urandom_range(6) != 0,
                    final_part);
  endfunction

  function automatic in_item_t noise_word();
    in_item_t w;
    w = byte_word($urandom);
    w.opcode = $urandom_range(3);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------

  // Offer one word, idle first at the current sender rate
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    forecast_decode(w);
    words_sent++;
  endtask

  // Hold the input until every predicted word is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_part_size(input logic [COUNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    part_size = v;
    size_writes++;
  endtask

  // Encode n random bytes the way a yEnc writer would, with line breaks
  task automatic send_encoded_part(input int n);
    logic [7:0] d, e;
    for (int i = 0; i < n; i++) begin
      d = $urandom;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: d = 8'h00 - OFFSET;
          1: d = CHAR_LF - OFFSET;
          2: d = CHAR_CR - OFFSET;
          default: d = CHAR_EQ - OFFSET;
        endcase
      end
      e = d + OFFSET;
      if (e == 8'h00 || e == CHAR_LF || e == CHAR_CR || e == CHAR_EQ ||
          ($urandom_range(15) == 0 && (e + ESC_OFFSET) != CHAR_CR &&
           (e + ESC_OFFSET) != CHAR_LF)) begin
        send_word(byte_word(CHAR_EQ));
        send_word(byte_word(e + ESC_OFFSET));
      end else begin
        send_word(byte_word(e));
      end
      if ($urandom_range(7) == 0) begin
        send_word(byte_word(CHAR_CR));
        send_word(byte_word(CHAR_LF));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  out_item_t want_word;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $error("output word with nothing expected: 0x%0h", out_data);
        errors++;
      end else begin
        want_word = due_words.pop_front();
        check_field("kind", want_word.kind, out_data.kind);
        check_field("decoded_byte", want_word.decoded_byte, out_data.decoded_byte);
        check_field("error_code", want_word.error_code, out_data.error_code);
        check_field("part_crc", want_word.part_crc, out_data.part_crc);
        check_field("file_crc", want_word.file_crc, out_data.file_crc);
        check_field("part_byte_count", want_word.part_byte_count,
                    out_data.part_byte_count);
        check_field("last", want_word.last, out_data.last);
        if (want_word.kind == KIND_SUMMARY) parts_closed++;
      end
      words_checked++;
    end
  end

  // Watchdog: stop when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Clean parts: reset part size of one, then three bytes with extremes
  task automatic test_clean_part();
    send_word(byte_word(8'h00));
    send_word(end_word(~crc32_fold(CRC_INIT, 8'h00 - OFFSET), 1'b1,
                       ~crc32_fold(CRC_INIT, 8'h00 - OFFSET), 1'b1, 1'b0));
    write_part_size(3);
    send_word(byte_word(8'hFF));
    send_word(byte_word(CHAR_CR));
    send_word(byte_word(CHAR_LF));
    send_word(byte_word(CHAR_EQ));
    send_word(byte_word(8'h6A));
    send_word(byte_word(8'h2A));
    send_word(trailer_word(1'b1));
  endtask

  // Escape handling: open at part end, before LF, escaped CR both ways
  task automatic test_escape_rules();
    send_word(op_word(OP_START_FILE));
    send_word(byte_word(CHAR_EQ));
    send_word(end_word(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_word(byte_word(CHAR_EQ));
    send_word(byte_word(CHAR_LF));
    send_word(byte_word(CHAR_EQ));
    send_word(byte_word(CHAR_CR));
    send_word(byte_word(8'h41));
    send_word(byte_word(CHAR_EQ));
    send_word(byte_word(CHAR_CR));
    send_word(byte_word(CHAR_LF));
    send_word(op_word(OP_UNUSED));
    send_word(end_word(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0));
  endtask

  // Part size extremes: zero, all ones and the saturation limit
  task automatic test_part_size_extremes();
    write_part_size('0);
    send_word(op_word(OP_START_FILE));
    send_word(byte_word($urandom));
    send_word(trailer_word(1'b0));
    write_part_size('1);
    send_word(byte_word($urandom));
    send_word(trailer_word(1'b0));
    write_part_size(MAX_PART_BYTES);
    send_word(byte_word($urandom));
    send_word(trailer_word(1'b1));
  endtask

  // One file: a size setting, then one to three parts, some broken
  task automatic run_random_file();
    int size, parts, n;
    size = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 8);
    write_part_size(size);
    send_word(op_word(OP_START_FILE));
    parts = $urandom_range(1, 3);
    for (int p = 0; p < parts; p++) begin
      n = size;
      case ($urandom_range(19))
        0: n = size + 1;
        1: n = size - 1;
        default: ;
      endcase
      send_encoded_part(n);
      if ($urandom_range(9) == 0) send_word(noise_word());
      if ($urandom_range(19) == 0) send_word(byte_word(CHAR_EQ));
      send_word(trailer_word(p == parts - 1));
    end
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 4) : 0) send_word(noise_word());
  endtask

  task automatic test_random_files(input int goal);
    while (words_sent < goal) run_random_file();
  endtask

  // Receiver stops for a long stretch while a full part streams in
  task automatic test_receiver_holdoff();
    write_part_size(48);
    send_word(op_word(OP_START_FILE));
    hold_reqs++;
    send_encoded_part(48);
    send_word(trailer_word(1'b1));
    settle();
  endtask

  initial begin
    part_size = 1;
    clear_file_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 32;
    rx_idle_pct = 86;
    test_clean_part();
    test_escape_rules();
    test_part_size_extremes();
    test_random_files(190);

    tx_idle_pct = 86;
    rx_idle_pct = 32;
    test_random_files(360);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_receiver_holdoff();
    test_random_files(530);

    settle();
    repeat (20) @(posedge clk);
    if (due_words.size() != 0) begin
      $error("%0d expected output words never arrived", due_words.size());
    end
    $display("Covered %0d input words, %0d output words, %0d part summaries, %0d size writes.",
             words_sent, words_checked, parts_closed, size_writes);
    $display("Idling ran sender-light, receiver-light and off, plus one long hold-off.");
    if (errors == 0 && due_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ybd_pkg.sv
sv/ybd_front.sv
sv/ybd_fifo.sv
sv/ybd_back.sv
sv/yenc_body_decoder_crc.sv
tb/sv/testbench.sv
